@@ rtl/gsa_pkg.sv @@
// shared constants, codes and controller/datapath interface types for the slot allocator
package gsa_pkg;

    localparam int MAX_ENTRIES = 8;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam logic [1:0] OP_REQUEST = 2'd0;
    localparam logic [1:0] OP_BEACON  = 2'd1;
    localparam logic [1:0] OP_REMOVE  = 2'd2;

    localparam logic [1:0] CFG_SLOTS     = 2'd0;
    localparam logic [1:0] CFG_BASE      = 2'd1;
    localparam logic [1:0] CFG_MIN_CAP   = 2'd2;
    localparam logic [1:0] CFG_ORDER     = 2'd3;

    localparam logic [4:0]  RST_SLOTS   = 5'd16;
    localparam logic [9:0]  RST_BASE    = 10'd60;
    localparam logic [23:0] RST_MIN_CAP = 24'd440;
    localparam logic [3:0]  RST_ORDER   = 4'd4;

    typedef struct packed {
        logic accept;
        logic walk_step;
        logic walk_end;
        logic mul;
        logic decide;
        logic emit;
        logic check_step;
        logic check_fail;
        logic check_empty;
        logic list_start;
        logic list_step;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       walk_more;
        logic       hit;
        logic       out_free;
        logic       fit_ok;
        logic       count_zero;
        logic       list_fin;
    } stat_t;

endpackage

@@ rtl/gts_slot_allocator.sv @@
// top level of the guaranteed time slot allocator: controller plus datapath
// one item at a time; the table walk touches one entry per cycle (N = entries held)
// slot request: table walk, multiply, compare, then the output register
// remove, or a request repeating its length: table walk, then the output register; unused opcode: output register only
//   beacon build: N-entry fit check, then one result per entry per cycle unless the output stalls, or one result
// reset: configuration returns to its defaults, the table is empty, no result pending
module gts_slot_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [15:0] owner_id,
    input  logic [3:0]  slot_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  granted_length,
    output logic        entry_valid,
    output logic [15:0] entry_owner,
    output logic [3:0]  entry_length,
    output logic [4:0]  entry_start,
    output logic [4:0]  cap_length,
    output logic        table_error,
    output logic        last
);

    gsa_pkg::cmd_t  cmd;
    gsa_pkg::stat_t stat;

    gsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .opcode   (opcode),
        .stat     (stat),
        .cmd      (cmd)
    );

    gsa_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .opcode         (opcode),
        .owner_id       (owner_id),
        .slot_count     (slot_count),
        .cmd            (cmd),
        .stat           (stat),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .granted_length (granted_length),
        .entry_valid    (entry_valid),
        .entry_owner    (entry_owner),
        .entry_length   (entry_length),
        .entry_start    (entry_start),
        .cap_length     (cap_length),
        .table_error    (table_error),
        .last           (last)
    );

endmodule

@@ rtl/gsa_ctrl.sv @@
// controller state machine sequencing table walks, the admission check and result output
module gsa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  gsa_pkg::stat_t     stat,
    output gsa_pkg::cmd_t      cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_WALK   = 7'b0000010,
        S_MUL    = 7'b0000100,
        S_DECIDE = 7'b0001000,
        S_EMIT   = 7'b0010000,
        S_CHECK  = 7'b0100000,
        S_LIST   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    case (opcode)
                        gsa_pkg::OP_REQUEST: state_next = S_WALK;
                        gsa_pkg::OP_REMOVE:  state_next = S_WALK;
                        gsa_pkg::OP_BEACON:  state_next = S_CHECK;
                        default:             state_next = S_EMIT;
                    endcase
                end
            end
            S_WALK:
            begin
                if (stat.walk_more)
                begin
                    cmd.walk_step = 1'b1;
                end
                else
                begin
                    cmd.walk_end = 1'b1;
                    if (stat.op == gsa_pkg::OP_REQUEST && !stat.hit)
                    begin
                        state_next = S_MUL;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CHECK:
            begin
                if (stat.walk_more)
                begin
                    if (stat.fit_ok)
                    begin
                        cmd.check_step = 1'b1;
                    end
                    else
                    begin
                        cmd.check_fail = 1'b1;
                        state_next     = S_EMIT;
                    end
                end
                else if (stat.count_zero)
                begin
                    cmd.check_empty = 1'b1;
                    state_next      = S_EMIT;
                end
                else
                begin
                    cmd.list_start = 1'b1;
                    state_next     = S_LIST;
                end
            end
            S_LIST:
            begin
                if (stat.out_free)
                begin
                    cmd.list_step = 1'b1;
                    if (stat.list_fin)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/gsa_dp.sv @@
// datapath: configuration registers, slot table, walk pointers, admission math, output register
module gsa_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic [1:0]         opcode,
    input  logic [15:0]        owner_id,
    input  logic [3:0]         slot_count,
    input  gsa_pkg::cmd_t      cmd,
    output gsa_pkg::stat_t     stat,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [3:0]         granted_length,
    output logic               entry_valid,
    output logic [15:0]        entry_owner,
    output logic [3:0]         entry_length,
    output logic [4:0]         entry_start,
    output logic [4:0]         cap_length,
    output logic               table_error,
    output logic               last
);

    logic [4:0]  sfs_reg;
    logic [9:0]  base_reg;
    logic [23:0] min_cap_reg;
    logic [3:0]  order_reg;

    logic [15:0] owner_mem [gsa_pkg::MAX_ENTRIES];
    logic [3:0]  len_mem   [gsa_pkg::MAX_ENTRIES];

    logic [1:0]                op_reg;
    logic [15:0]               own_reg;
    logic [3:0]                want_reg;
    logic [gsa_pkg::CNT_W-1:0] rd_reg;
    logic [gsa_pkg::CNT_W-1:0] wr_reg;
    logic [gsa_pkg::CNT_W-1:0] count_reg;
    logic signed [8:0]         cap_reg;
    logic                      hit_reg;
    logic [14:0]               prod_reg;
    logic                      neg_reg;
    logic [3:0]                res_granted_reg;
    logic [4:0]                res_cap_reg;
    logic                      res_err_reg;
    logic                      out_valid_reg;
    logic [15:0]               rd_owner_reg;
    logic [3:0]                rd_len_reg;

    logic [3:0]  granted_reg;
    logic        ent_valid_reg;
    logic [15:0] ent_owner_reg;
    logic [3:0]  ent_len_reg;
    logic [4:0]  ent_start_reg;
    logic [4:0]  cap_out_reg;
    logic        err_reg;
    logic        last_reg;

    logic [gsa_pkg::CNT_W-1:0] rd_next;
    logic [gsa_pkg::IDX_W-1:0] rd_idx;
    logic [gsa_pkg::IDX_W-1:0] wr_idx;
    logic [gsa_pkg::IDX_W-1:0] app_idx;
    logic [15:0]               rd_owner;
    logic [3:0]                rd_len;
    logic                      match;
    logic                      keep_eq;
    logic                      drop;
    logic signed [8:0]         margin;
    logic [29:0]               shifted;
    logic                      grant;
    logic [4:0]                new_cap;
    logic                      fin;
    logic                      out_free;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        rd_next = rd_reg;
        if (cmd.accept || cmd.list_start)
        begin
            rd_next = '0;
        end
        else if (cmd.walk_step || cmd.check_step || cmd.list_step)
        begin
            rd_next = rd_reg + gsa_pkg::CNT_W'(1);
        end
    end

    assign rd_idx   = rd_next[gsa_pkg::IDX_W-1:0];
    assign wr_idx   = wr_reg[gsa_pkg::IDX_W-1:0];
    assign app_idx  = count_reg[gsa_pkg::IDX_W-1:0];
    assign rd_owner = rd_owner_reg;
    assign rd_len   = rd_len_reg;

    // equal-length hit keeps the entry and ends matching; any other match is dropped
    assign match   = (rd_owner == own_reg) && !hit_reg;
    assign keep_eq = match && (op_reg == gsa_pkg::OP_REQUEST) && (rd_len == want_reg);
    assign drop    = match && !keep_eq;

    assign margin  = cap_reg - $signed({5'b0, want_reg});
    assign shifted = {15'b0, prod_reg} << order_reg;
    assign grant   = (want_reg != 4'd0)
                     && (count_reg < gsa_pkg::CNT_W'(gsa_pkg::MAX_ENTRIES))
                     && !neg_reg
                     && (shifted >= {6'b0, min_cap_reg});

    assign new_cap  = cap_reg[4:0] - {1'b0, rd_len};
    assign fin      = ((rd_reg + gsa_pkg::CNT_W'(1)) == count_reg);
    assign out_free = !out_valid_reg || out_ready;

    assign stat.op         = op_reg;
    assign stat.walk_more  = (rd_reg < count_reg);
    assign stat.hit        = hit_reg;
    assign stat.out_free   = out_free;
    assign stat.fit_ok     = (cap_reg[4:0] > {1'b0, rd_len});
    assign stat.count_zero = (count_reg == '0);
    assign stat.list_fin   = fin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sfs_reg     <= gsa_pkg::RST_SLOTS;
            base_reg    <= gsa_pkg::RST_BASE;
            min_cap_reg <= gsa_pkg::RST_MIN_CAP;
            order_reg   <= gsa_pkg::RST_ORDER;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                gsa_pkg::CFG_SLOTS:   sfs_reg     <= cfg_data[4:0];
                gsa_pkg::CFG_BASE:    base_reg    <= cfg_data[9:0];
                gsa_pkg::CFG_MIN_CAP: min_cap_reg <= cfg_data;
                gsa_pkg::CFG_ORDER:   order_reg   <= cfg_data[3:0];
                default:              sfs_reg     <= sfs_reg;
            endcase
        end
    end

    // slot table, compacted in place during a walk; read data follows the pointer's next value
    always_ff @(posedge clk)
    begin
        rd_owner_reg <= owner_mem[rd_idx];
        rd_len_reg   <= len_mem[rd_idx];
        if (cmd.walk_step && !drop)
        begin
            owner_mem[wr_idx] <= rd_owner;
            len_mem[wr_idx]   <= rd_len;
        end
        else if (cmd.decide && grant)
        begin
            owner_mem[app_idx] <= own_reg;
            len_mem[app_idx]   <= want_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg          <= gsa_pkg::OP_REQUEST;
            own_reg         <= '0;
            want_reg        <= '0;
            rd_reg          <= '0;
            wr_reg          <= '0;
            count_reg       <= '0;
            cap_reg         <= '0;
            hit_reg         <= 1'b0;
            prod_reg        <= '0;
            neg_reg         <= 1'b0;
            res_granted_reg <= '0;
            res_cap_reg     <= '0;
            res_err_reg     <= 1'b0;
        end
        else
        begin
            rd_reg <= rd_next;
            if (cmd.accept)
            begin
                op_reg          <= opcode;
                own_reg         <= owner_id;
                want_reg        <= slot_count;
                wr_reg          <= '0;
                cap_reg         <= $signed({4'b0, sfs_reg});
                hit_reg         <= 1'b0;
                res_granted_reg <= '0;
                res_cap_reg     <= '0;
                res_err_reg     <= 1'b0;
            end
            if (cmd.walk_step)
            begin
                if (!drop)
                begin
                    wr_reg <= wr_reg + gsa_pkg::CNT_W'(1);
                end
                if (keep_eq)
                begin
                    hit_reg         <= 1'b1;
                    res_granted_reg <= want_reg;
                end
                if (!match)
                begin
                    cap_reg <= cap_reg - $signed({5'b0, rd_len});
                end
            end
            if (cmd.walk_end)
            begin
                count_reg <= wr_reg;
            end
            if (cmd.mul)
            begin
                prod_reg <= {10'b0, margin[4:0]} * {5'b0, base_reg};
                neg_reg  <= margin[8];
            end
            if (cmd.decide && grant)
            begin
                res_granted_reg <= want_reg;
                count_reg       <= count_reg + gsa_pkg::CNT_W'(1);
            end
            if (cmd.check_step)
            begin
                cap_reg <= cap_reg - $signed({5'b0, rd_len});
            end
            if (cmd.check_fail)
            begin
                count_reg   <= '0;
                res_cap_reg <= sfs_reg;
                res_err_reg <= 1'b1;
            end
            if (cmd.check_empty)
            begin
                res_cap_reg <= sfs_reg;
            end
            if (cmd.list_start)
            begin
                cap_reg <= $signed({4'b0, sfs_reg});
            end
            if (cmd.list_step)
            begin
                cap_reg <= $signed({4'b0, new_cap});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit || cmd.list_step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            granted_reg   <= res_granted_reg;
            ent_valid_reg <= 1'b0;
            ent_owner_reg <= '0;
            ent_len_reg   <= '0;
            ent_start_reg <= '0;
            cap_out_reg   <= res_cap_reg;
            err_reg       <= res_err_reg;
            last_reg      <= 1'b1;
        end
        else if (cmd.list_step)
        begin
            granted_reg   <= '0;
            ent_valid_reg <= 1'b1;
            ent_owner_reg <= rd_owner;
            ent_len_reg   <= rd_len;
            ent_start_reg <= new_cap + 5'd1;
            cap_out_reg   <= fin ? new_cap : 5'd0;
            err_reg       <= 1'b0;
            last_reg      <= fin;
        end
    end

    assign out_valid      = out_valid_reg;
    assign granted_length = granted_reg;
    assign entry_valid    = ent_valid_reg;
    assign entry_owner    = ent_owner_reg;
    assign entry_length   = ent_len_reg;
    assign entry_start    = ent_start_reg;
    assign cap_length     = cap_out_reg;
    assign table_error    = err_reg;
    assign last           = last_reg;

endmodule

@@ rtl/gsa_checker.sv @@
// port-level checker for the slot allocator and its bind to the top level
module gsa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  granted_length,
    input logic        entry_valid,
    input logic [15:0] entry_owner,
    input logic [3:0]  entry_length,
    input logic [4:0]  entry_start,
    input logic [4:0]  cap_length,
    input logic        table_error,
    input logic        last
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(entry_owner)
            && $stable(last) && $stable(granted_length))
        else $error("result item changed while stalled");

    // listed entries never carry a grant or an error
    a_entry_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && entry_valid |-> granted_length == 4'd0 && !table_error)
        else $error("entry item carries grant or error");

    // a table error is always a lone final item
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && table_error |-> last && !entry_valid)
        else $error("table error item not final");

    // only beacon lists span more than one result item
    a_multi_entry: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> entry_valid)
        else $error("non-final item without an entry");

endmodule

bind gts_slot_allocator gsa_checker u_gsa_checker (.*);
